### hw/rtl/uvs_pkg.sv
package uvs_pkg;

  localparam int DIV_LAT = 18;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int PIPE_LAT = DIV_LAT + CORDIC_LAT + 4;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic [31:0] AtanTurns [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    REG_RING    = 2'd0,
    REG_SEGMENT = 2'd1,
    REG_RADIUS  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] base;
    logic        quad;
  } tag_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] base;
    logic        quad;
  } attr_t;

  function automatic logic signed [15:0] clamp_unit(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd16384) begin
      r = 16'sd16384;
    end else if (v < -34'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/uvs_div.sv
module uvs_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [7:0]                   num_i,
  input  logic [7:0]                   den_i,
  output logic [uvs_pkg::DIV_LAT-1:0]  quo_o
);

  localparam int QW = uvs_pkg::DIV_LAT;

  logic [7:0]    rem_q [0:QW-2];
  logic [QW-1:0] quo_q [0:QW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q[0] <= {{(QW-1){1'b0}}, (num_i == den_i)};
      rem_q[0] <= (num_i == den_i) ? 8'd0 : num_i;
    end
  end

  generate
    for (genvar k = 1; k < QW; k++) begin : g_step
      logic [8:0] t;
      logic       ge;
      logic [8:0] diff;
      assign t    = {rem_q[k-1], 1'b0};
      assign ge   = (t >= {1'b0, den_i});
      assign diff = t - {1'b0, den_i};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        end
      end
      if (k < QW - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[k] <= ge ? diff[7:0] : t[7:0];
          end
        end
      end
    end
  endgenerate

  assign quo_o = quo_q[QW-1];

endmodule

### hw/rtl/uvs_cordic.sv
module uvs_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  localparam int N = uvs_pkg::CORDIC_STEPS;

  logic signed [33:0] x_q [0:N];
  logic signed [33:0] y_q [0:N];
  logic signed [32:0] z_q [0:N-1];
  logic [1:0]         quad_q [0:N];

  logic [31:0]        shifted;
  logic [1:0]         quad_d;
  logic [31:0]        resid_d;
  logic signed [33:0] c_d;
  logic signed [33:0] s_d;
  logic signed [33:0] c_rnd;
  logic signed [33:0] s_rnd;

  assign shifted = phase_i + 32'h2000_0000;
  assign quad_d  = shifted[31:30];
  assign resid_d = phase_i - {quad_d, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= uvs_pkg::CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({resid_d[31], resid_d});
      quad_q[0] <= quad_d;
    end
  end

  generate
    for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [32:0] at;
      assign xs = x_q[i] >>> i;
      assign ys = y_q[i] >>> i;
      assign at = $signed({1'b0, uvs_pkg::AtanTurns[i]});
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_q[i][32]) begin
            x_q[i+1] <= x_q[i] - ys;
            y_q[i+1] <= y_q[i] + xs;
          end else begin
            x_q[i+1] <= x_q[i] + ys;
            y_q[i+1] <= y_q[i] - xs;
          end
          quad_q[i+1] <= quad_q[i];
        end
      end
      if (i < N - 1) begin : g_z
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            z_q[i+1] <= z_q[i][32] ? (z_q[i] + at) : (z_q[i] - at);
          end
        end
      end
    end
  endgenerate

  always_comb begin
    unique case (quad_q[N])
      2'd0: begin
        c_d = x_q[N];
        s_d = y_q[N];
      end
      2'd1: begin
        c_d = -y_q[N];
        s_d = x_q[N];
      end
      2'd2: begin
        c_d = -x_q[N];
        s_d = -y_q[N];
      end
      default: begin
        c_d = y_q[N];
        s_d = -x_q[N];
      end
    endcase
  end

  assign c_rnd = (c_d + 34'sd32768) >>> 16;
  assign s_rnd = (s_d + 34'sd32768) >>> 16;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= uvs_pkg::clamp_unit(c_rnd);
      sin_o <= uvs_pkg::clamp_unit(s_rnd);
    end
  end

endmodule

### hw/rtl/uv_sphere_vertex_generator.sv
// Throughput: one item per cycle when the output is not stalled; every stage is registered,
// latency mostly set by the 18-stage dividers and 26-stage CORDICs.
// An output stall while out_valid_o is high freezes the whole pipeline and stalls the input.
// Reset: asynchronous, active low; clears valid bits and loads ring_count 20,
// segment_count 20, sphere_radius 256 (1.0).
module uv_sphere_vertex_generator #(
  parameter int INDEX_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ring_pos_i,
  input  logic [7:0]         segment_pos_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [15:0]        base_index_o,
  output logic               quad_valid_o
);

  localparam int DL = uvs_pkg::DIV_LAT;
  localparam int CL = uvs_pkg::CORDIC_LAT;
  localparam int PL = uvs_pkg::PIPE_LAT;

  logic [7:0]  ring_cnt_q;
  logic [7:0]  seg_cnt_q;
  logic [15:0] radius_q;

  logic        en;
  logic [PL-1:0] vld_q;

  logic [7:0]  rc_d;
  logic [7:0]  sc_d;
  logic [7:0]  r_d;
  logic [7:0]  s_d;
  logic [16:0] base_full;

  logic [7:0]  r_q;
  logic [7:0]  s_q;
  logic [7:0]  rc_q;
  logic [7:0]  sc_q;

  uvs_pkg::tag_t  tag_q [0:DL];
  uvs_pkg::attr_t attr_q [0:CL];
  uvs_pkg::attr_t attr_m_q;

  logic [DL-1:0] quo_r;
  logic [DL-1:0] quo_s;
  logic [DL-1:0] phi_t;
  logic [DL-1:0] th_t;
  logic [DL-1:0] tu_t;
  logic [DL-1:0] tv_t;

  logic [INDEX_BITS-1:0] phi_q;
  logic [INDEX_BITS-1:0] theta_q;

  logic signed [15:0] cphi;
  logic signed [15:0] sphi;
  logic signed [15:0] cth;
  logic signed [15:0] sth;

  logic signed [31:0] px_prod;
  logic signed [31:0] pz_prod;
  logic signed [33:0] px_rnd;
  logic signed [33:0] pz_rnd;

  logic signed [15:0] nx_q;
  logic signed [15:0] ny_q;
  logic signed [15:0] nz_q;

  logic signed [16:0] rad_s;
  logic signed [32:0] mx;
  logic signed [32:0] my;
  logic signed [32:0] mz;
  logic signed [32:0] mx_r;
  logic signed [32:0] my_r;
  logic signed [32:0] mz_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cnt_q <= 8'd20;
      seg_cnt_q  <= 8'd20;
      radius_q   <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uvs_pkg::REG_RING:    ring_cnt_q <= cfg_data_i[7:0];
        uvs_pkg::REG_SEGMENT: seg_cnt_q  <= cfg_data_i[7:0];
        uvs_pkg::REG_RADIUS:  radius_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PL-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[PL-1];

  assign rc_d = (ring_cnt_q == 8'd0) ? 8'd1 : ring_cnt_q;
  assign sc_d = (seg_cnt_q == 8'd0) ? 8'd1 : seg_cnt_q;
  assign r_d  = (ring_pos_i > rc_d) ? rc_d : ring_pos_i;
  assign s_d  = (segment_pos_i > sc_d) ? sc_d : segment_pos_i;
  assign base_full = 17'(r_d) * 17'({1'b0, sc_d} + 9'd1) + 17'(s_d);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q  <= r_d;
      s_q  <= s_d;
      rc_q <= rc_d;
      sc_q <= sc_d;
      tag_q[0].base <= base_full[15:0];
      tag_q[0].quad <= (r_d < rc_d) && (s_d < sc_d);
    end
  end

  uvs_div u_div_ring (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (r_q),
    .den_i (rc_q),
    .quo_o (quo_r)
  );

  uvs_div u_div_seg (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s_q),
    .den_i (sc_q),
    .quo_o (quo_s)
  );

  generate
    for (genvar k = 1; k <= DL; k++) begin : g_tag
      always_ff @(posedge clk_i) begin
        if (en) begin
          tag_q[k] <= tag_q[k-1];
        end
      end
    end
  endgenerate

  assign phi_t = (quo_r >> (DL - 1 - INDEX_BITS)) + DL'(1);
  assign th_t  = (quo_s >> (DL - 2 - INDEX_BITS)) + DL'(1);
  assign tu_t  = quo_s + DL'(1);
  assign tv_t  = quo_r + DL'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      phi_q   <= phi_t[INDEX_BITS:1];
      theta_q <= th_t[INDEX_BITS:1];
      attr_q[0].tex_u <= tu_t[DL-1:1];
      attr_q[0].tex_v <= tv_t[DL-1:1];
      attr_q[0].base  <= tag_q[DL].base;
      attr_q[0].quad  <= tag_q[DL].quad;
    end
  end

  uvs_cordic u_cordic_phi (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i ({phi_q, {(32-INDEX_BITS){1'b0}}}),
    .cos_o   (cphi),
    .sin_o   (sphi)
  );

  uvs_cordic u_cordic_theta (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i ({theta_q, {(32-INDEX_BITS){1'b0}}}),
    .cos_o   (cth),
    .sin_o   (sth)
  );

  generate
    for (genvar k = 1; k <= CL; k++) begin : g_attr
      always_ff @(posedge clk_i) begin
        if (en) begin
          attr_q[k] <= attr_q[k-1];
        end
      end
    end
  endgenerate

  assign px_prod = sphi * cth;
  assign pz_prod = sphi * sth;
  assign px_rnd  = (34'(px_prod) + 34'sd8192) >>> 14;
  assign pz_rnd  = (34'(pz_prod) + 34'sd8192) >>> 14;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q     <= uvs_pkg::clamp_unit(px_rnd);
      ny_q     <= cphi;
      nz_q     <= uvs_pkg::clamp_unit(pz_rnd);
      attr_m_q <= attr_q[CL];
    end
  end

  assign rad_s = $signed({1'b0, radius_q});
  assign mx    = 33'(nx_q) * 33'(rad_s);
  assign my    = 33'(ny_q) * 33'(rad_s);
  assign mz    = 33'(nz_q) * 33'(rad_s);
  assign mx_r  = (mx + 33'sd8192) >>> 14;
  assign my_r  = (my + 33'sd8192) >>> 14;
  assign mz_r  = (mz + 33'sd8192) >>> 14;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_o      <= mx_r[16:0];
      pos_y_o      <= my_r[16:0];
      pos_z_o      <= mz_r[16:0];
      norm_x_o     <= nx_q;
      norm_y_o     <= ny_q;
      norm_z_o     <= nz_q;
      tex_u_o      <= attr_m_q.tex_u;
      tex_v_o      <= attr_m_q.tex_v;
      base_index_o <= attr_m_q.base;
      quad_valid_o <= attr_m_q.quad;
    end
  end

`ifndef SYNTHESIS
  a_quad_inside_texture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && quad_valid_o) |-> (tex_u_o != 17'h10000 && tex_v_o != 17'h10000))
    else $error("quad flagged on the last ring or segment");

  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && radius_q == 16'd0) |->
      (pos_x_o == 17'sd0 && pos_y_o == 17'sd0 && pos_z_o == 17'sd0))
    else $error("nonzero position with zero radius");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (norm_x_o <= 16'sd16384 && norm_x_o >= -16'sd16384 &&
                     norm_z_o <= 16'sd16384 && norm_z_o >= -16'sd16384))
    else $error("normal component out of unit range");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam int IdleLimit = 5000;
  localparam int HoldOffCycles = 300;

  typedef struct {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        base_index;
    logic               quad_valid;
  } vertex_t;

  class vertex_board;
    vertex_t pending[$];
    int      fails;
    int      rings;
    int      segments;
    int      radius;

    function new();
      fails = 0;
      rings = 20;
      segments = 20;
      radius = 256;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fails++;
    endtask

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        uvs_pkg::REG_RING:    rings = value[7:0];
        uvs_pkg::REG_SEGMENT: segments = value[7:0];
        uvs_pkg::REG_RADIUS:  radius = value;
        default:     ;
      endcase
    endfunction

    function longint unit_clamp(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
    endfunction

    function longint q14_mul(longint a, longint b);
      return (a * b + 8192) >>> 14;
    endfunction

    function void turn_sincos(logic [31:0] phase, output longint c, output longint s);
      logic [1:0]  quadrant;
      logic [31:0] resid;
      longint      x, y, z, nx, ny;
      quadrant = 2'((phase + 32'h20000000) >> 30);
      resid = phase - ({30'd0, quadrant} << 30);
      z = longint'($signed(resid));
      x = longint'(uvs_pkg::CordicGain);
      y = 0;
      for (int i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z = z - longint'(uvs_pkg::AtanTurns[i]);
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z = z + longint'(uvs_pkg::AtanTurns[i]);
        end
        x = nx;
        y = ny;
      end
      case (quadrant)
        2'd0: begin nx = x;  ny = y;  end
        2'd1: begin nx = -y; ny = x;  end
        2'd2: begin nx = -x; ny = -y; end
        default: begin nx = y; ny = -x; end
      endcase
      c = unit_clamp((nx + 32768) >>> 16);
      s = unit_clamp((ny + 32768) >>> 16);
    endfunction

    function void note_item(int ring_in, int seg_in);
      vertex_t v;
      longint  rc, sc, r, s, pphi, pth, cphi, sphi, cth, sth, nx, nz;
      rc = (rings == 0) ? 1 : rings;
      sc = (segments == 0) ? 1 : segments;
      r = (ring_in > rc) ? rc : ring_in;
      s = (seg_in > sc) ? sc : seg_in;
      pphi = (r * 128 + rc / 2) / rc;
      pth = ((s * 256 + sc / 2) / sc) & 255;
      turn_sincos(32'(pphi) << 24, cphi, sphi);
      turn_sincos(32'(pth) << 24, cth, sth);
      nx = unit_clamp(q14_mul(sphi, cth));
      nz = unit_clamp(q14_mul(sphi, sth));
      v.pos_x = 17'(q14_mul(nx, radius));
      v.pos_y = 17'(q14_mul(cphi, radius));
      v.pos_z = 17'(q14_mul(nz, radius));
      v.norm_x = 16'(nx);
      v.norm_y = 16'(cphi);
      v.norm_z = 16'(nz);
      v.tex_u = 17'((s * 65536 + sc / 2) / sc);
      v.tex_v = 17'((r * 65536 + rc / 2) / rc);
      v.base_index = 16'(r * (sc + 1) + s);
      v.quad_valid = (r < rc && s < sc);
      pending.insert(pending.size(), v);
    endfunction

    task check(vertex_t got);
      vertex_t want;
      if (pending.size() == 0) begin
        report("unexpected vertex");
        return;
      end
      want = pending.pop_front();
      if (got.pos_x !== want.pos_x)
        report($sformatf("pos_x %0d want %0d", got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report($sformatf("pos_y %0d want %0d", got.pos_y, want.pos_y));
      if (got.pos_z !== want.pos_z)
        report($sformatf("pos_z %0d want %0d", got.pos_z, want.pos_z));
      if (got.norm_x !== want.norm_x)
        report($sformatf("norm_x %0d want %0d", got.norm_x, want.norm_x));
      if (got.norm_y !== want.norm_y)
        report($sformatf("norm_y %0d want %0d", got.norm_y, want.norm_y));
      if (got.norm_z !== want.norm_z)
        report($sformatf("norm_z %0d want %0d", got.norm_z, want.norm_z));
      if (got.tex_u !== want.tex_u)
        report($sformatf("tex_u %0d want %0d", got.tex_u, want.tex_u));
      if (got.tex_v !== want.tex_v)
        report($sformatf("tex_v %0d want %0d", got.tex_v, want.tex_v));
      if (got.base_index !== want.base_index)
        report($sformatf("base_index %0d want %0d", got.base_index, want.base_index));
      if (got.quad_valid !== want.quad_valid)
        report($sformatf("quad_valid %0b want %0b", got.quad_valid, want.quad_valid));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         ring_pos_i = '0;
  logic [7:0]         segment_pos_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o;
  logic [16:0]        tex_u_o, tex_v_o;
  logic [15:0]        base_index_o;
  logic               quad_valid_o;

  vertex_board board = new();
  bit quiet = 1'b0;
  int idle_cycles = 0;
  int run_cycles = 0;

  uv_sphere_vertex_generator u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni) begin
      run_cycles++;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        got.pos_x = pos_x_o;
        got.pos_y = pos_y_o;
        got.pos_z = pos_z_o;
        got.norm_x = norm_x_o;
        got.norm_y = norm_y_o;
        got.norm_z = norm_z_o;
        got.tex_u = tex_u_o;
        got.tex_v = tex_v_o;
        got.base_index = base_index_o;
        got.quad_valid = quad_valid_o;
        board.check(got);
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts until quiet is set, one long hold-off while items stream in
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && run_cycles > 60) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task send_point(int ring, int seg);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ring_pos_i <= 8'(ring);
    segment_pos_i <= 8'(seg);
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(ring, seg);
    @(negedge clk_i);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    board.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task set_sphere(int rings, int segs, int radius);
    drain();
    write_reg(uvs_pkg::REG_RING, 16'(rings));
    write_reg(uvs_pkg::REG_SEGMENT, 16'(segs));
    write_reg(uvs_pkg::REG_RADIUS, 16'(radius));
  endtask

  task random_points(int count);
    int r, s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, (board.rings == 0) ? 1 : board.rings);
        s = $urandom_range(0, (board.segments == 0) ? 1 : board.segments);
      end else begin
        r = $urandom_range(0, 255);
        s = $urandom_range(0, 255);
      end
      send_point(r, s);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_point(0, 0);
    send_point(20, 20);
    send_point(20, 0);
    send_point(0, 20);
    send_point(255, 255);
    send_point(10, 5);
    send_point(19, 19);
    send_point(5, 255);
    send_point(255, 3);
    send_point(10, 10);
    send_point(7, 15);
    random_points(110);

    drain();
    write_reg(RegSpare, 16'hFFFF);
    random_points(20);
    set_sphere(1, 1, 65535);
    send_point(0, 0);
    send_point(1, 1);
    send_point(0, 1);
    send_point(255, 0);
    random_points(60);
    set_sphere(255, 255, 0);
    send_point(255, 255);
    send_point(254, 254);
    random_points(80);
    set_sphere(0, 0, 256);
    send_point(0, 0);
    send_point(1, 1);
    send_point(128, 200);
    random_points(60);
    set_sphere(255, 255, 65535);
    random_points(100);
    set_sphere(7, 13, 12345);
    random_points(90);
    set_sphere($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 65535));
    random_points(90);
    drain();
    quiet = 1'b1;
    set_sphere(20, 20, 256);
    random_points(100);

    drain();
    repeat (60) @(posedge clk_i);
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
